// ----- sv/epvr_pkg.sv -----
// Shared types, constants and CRC helpers for the package validator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package epvr_pkg;

  localparam logic [31:0] HdrMagic   = 32'h4558_4531;
  localparam logic [31:0] HdrSize    = 32'd32;
  localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;
  localparam logic        KindLoad   = 1'b0;
  localparam logic        KindRead   = 1'b1;
  localparam logic        CfgLoadBase = 1'b0;
  localparam logic        CfgCapLimit = 1'b1;
  localparam logic [16:0] CapReset   = 17'h1_0000;

  // One queued command, less the stream position whose width follows the buffer.
  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic        fin;
    logic [15:0] addr;
    logic [31:0] crc;
  } cmd_t;

  function automatic logic [31:0] crc_tab(input logic [3:0] i);
    logic [31:0] v;
    case (i)
      4'h0: v = 32'h0000_0000; 4'h1: v = 32'h1db7_1064;
      4'h2: v = 32'h3b6e_20c8; 4'h3: v = 32'h26d9_30ac;
      4'h4: v = 32'h76dc_4190; 4'h5: v = 32'h6b6b_51f4;
      4'h6: v = 32'h4db2_6158; 4'h7: v = 32'h5005_713c;
      4'h8: v = 32'hedb8_8320; 4'h9: v = 32'hf00f_9344;
      4'ha: v = 32'hd6d6_a3e8; 4'hb: v = 32'hcb61_b38c;
      4'hc: v = 32'h9b64_c2b0; 4'hd: v = 32'h86d3_d2d4;
      4'he: v = 32'ha00a_e278; 4'hf: v = 32'hbdbd_f21c;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'h0, b};
    x = (x >> 4) ^ crc_tab(x[3:0]);
    x = (x >> 4) ^ crc_tab(x[3:0]);
    return x;
  endfunction

endpackage
`default_nettype wire

// ----- sv/epvr_front.sv -----
// Front end: counts stream position and runs the CRC, packs commands.
// Depends on epvr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module epvr_front import epvr_pkg::*; #(
  parameter int BUFFER_BYTES = 65536,
  parameter int CW = $clog2(BUFFER_BYTES + 2)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          take_i,
  input  wire logic          kind_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          final_byte_i,
  input  wire logic [15:0]   read_address_i,
  output cmd_t               cmd_o,
  output logic [CW-1:0]      pos_o
);
  localparam logic [CW-1:0] BufTop = CW'(BUFFER_BYTES);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   crc_q, crc_d, crc_nx;
  logic          in_crc_field;

  assign in_crc_field = (cnt_q >= CW'(24)) && (cnt_q < CW'(28));
  assign crc_nx = crc_byte(crc_q, in_crc_field ? 8'h00 : data_byte_i);

  always_comb begin
    cnt_d = cnt_q;
    crc_d = crc_q;
    if (take_i && kind_i == KindLoad) begin
      if (final_byte_i) begin
        cnt_d = '0;
        crc_d = CrcInit;
      end else begin
        crc_d = crc_nx;
        if (cnt_q <= BufTop) cnt_d = cnt_q + CW'(1);
      end
    end
  end

  assign cmd_o.kind = kind_i;
  assign cmd_o.data = data_byte_i;
  assign cmd_o.fin  = final_byte_i;
  assign cmd_o.addr = read_address_i;
  assign cmd_o.crc  = crc_nx;
  assign pos_o      = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      crc_q <= CrcInit;
    end else begin
      cnt_q <= cnt_d;
      crc_q <= crc_d;
    end
  end
endmodule
`default_nettype wire

// ----- sv/epvr_queue.sv -----
// Two-entry command queue between front end and back end.
// Depends on nothing but a data width.
`timescale 1ns / 1ps
`default_nettype none
module epvr_queue #(
  parameter int DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [DW-1:0] push_data_i,
  input  wire logic          pop_i,
  output logic [DW-1:0]      pop_data_o,
  output logic               valid_o,
  output logic               full_o
);
  logic [DW-1:0] ent_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    fill_q;

  assign valid_o    = fill_q != 2'd0;
  assign full_o     = fill_q == 2'd2;
  assign pop_data_o = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

// ----- sv/epvr_back.sv -----
// Back end: byte store, header and relocation sequencer, read replies.
// Depends on epvr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module epvr_back import epvr_pkg::*; #(
  parameter int BUFFER_BYTES = 65536,
  parameter int CW = $clog2(BUFFER_BYTES + 2),
  parameter int AW = $clog2(BUFFER_BYTES)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  cmd_t               cmd_i,
  input  wire logic [CW-1:0] pos_i,
  output logic               cmd_pop_o,
  input  wire logic [31:0]   load_base_i,
  input  wire logic [16:0]   cap_i,
  output logic               res_valid_o,
  output logic               is_read_reply_o,
  output logic               package_ok_o,
  output logic [31:0]        entry_address_o,
  output logic [16:0]        memory_size_o,
  output logic [7:0]         read_data_o
);
  localparam logic [3:0] S_IDLE = 4'd0, S_FETCH = 4'd1, S_HDR = 4'd2, S_CHK1 = 4'd3,
                         S_CHK2 = 4'd4, S_OFFC = 4'd5, S_TGTC = 4'd6, S_OFF2 = 4'd7,
                         S_TGT2 = 4'd8, S_WR = 4'd9, S_OK = 4'd10, S_RDW = 4'd11;
  localparam logic [CW-1:0] BufTop = CW'(BUFFER_BYTES);
  localparam logic [AW-1:0] TblBase = AW'(32);

  logic [7:0]    mem [BUFFER_BYTES];
  logic [AW-1:0] ma;
  logic          mwe;
  logic [7:0]    mwd, rdata_q;

  logic [3:0]    st_q, st_d, ret_q, ret_d;
  logic [2:0]    fcnt_q, fcnt_d, hidx_q, hidx_d;
  logic [AW-1:0] faddr_q, faddr_d, ptr_q, ptr_d, taddr_q, taddr_d;
  logic [31:0]   fword_q, fword_d, off_q, off_d, prev_q, prev_d, sum_q, sum_d;
  logic [31:0]   hdr_q [8];
  logic          hdr_we;
  logic [CW-1:0] n_q, n_d, start_q, start_d, idx_q, idx_d, img_start_q, img_start_d;
  logic [31:0]   crcf_q, crcf_d;
  logic [1:0]    wcnt_q, wcnt_d;
  logic          img_valid_q, img_valid_d;
  logic [16:0]   img_len_q, img_len_d, mem_len_q, mem_len_d;

  logic          rv_d, rk_d, rok_d;
  logic [31:0]   rent_d;
  logic [16:0]   rmem_d;
  logic [7:0]    rdat_d;

  logic [CW-1:0] n_in;
  logic [31:0]   n32, start32, image, memory, entry, count, fw_full;
  logic          last_idx;

  assign n_in    = (pos_i <= BufTop) ? pos_i + CW'(1) : pos_i;
  assign n32     = 32'(n_q);
  assign image   = hdr_q[2];
  assign memory  = hdr_q[3];
  assign entry   = hdr_q[4];
  assign count   = hdr_q[5];
  assign start32 = 32'd32 + {count[29:0], 2'b00};
  assign fw_full = fword_q;
  assign last_idx = (32'(idx_q) + 32'd1) == count;

  always_ff @(posedge clk_i) begin
    if (mwe) mem[ma] <= mwd;
    rdata_q <= mem[ma];
    if (hdr_we) hdr_q[hidx_q] <= fword_q;
  end

  always_comb begin
    st_d = st_q; ret_d = ret_q; fcnt_d = fcnt_q; hidx_d = hidx_q;
    faddr_d = faddr_q; ptr_d = ptr_q; taddr_d = taddr_q; fword_d = fword_q;
    off_d = off_q; prev_d = prev_q; sum_d = sum_q; n_d = n_q; start_d = start_q;
    idx_d = idx_q; crcf_d = crcf_q; wcnt_d = wcnt_q; img_valid_d = img_valid_q;
    img_len_d = img_len_q; mem_len_d = mem_len_q; img_start_d = img_start_q;
    rv_d = 1'b0; rk_d = is_read_reply_o; rok_d = package_ok_o; rent_d = entry_address_o;
    rmem_d = memory_size_o; rdat_d = read_data_o;
    ma = faddr_q; mwe = 1'b0; mwd = 8'h00; hdr_we = 1'b0; cmd_pop_o = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == KindLoad) begin
            img_valid_d = 1'b0;
            ma  = pos_i[AW-1:0];
            mwe = pos_i < BufTop;
            mwd = cmd_i.data;
            if (cmd_i.fin) begin
              n_d = n_in;
              crcf_d = cmd_i.crc;
              if (n_in > BufTop || n_in < CW'(32) || 32'(n_in) > 32'(cap_i) ||
                  load_base_i[0]) begin
                rv_d = 1'b1; rk_d = 1'b0; rok_d = 1'b0; rent_d = '0; rmem_d = '0;
                rdat_d = '0;
              end else begin
                hidx_d = '0; faddr_d = '0; fcnt_d = '0; ret_d = S_HDR; st_d = S_FETCH;
              end
            end
          end else if (img_valid_q && {1'b0, cmd_i.addr} < img_len_q) begin
            ma = AW'(32'(img_start_q) + 32'(cmd_i.addr));
            st_d = S_RDW;
          end else begin
            rv_d = 1'b1; rk_d = 1'b1; rok_d = 1'b0; rent_d = '0; rmem_d = '0;
            rdat_d = '0;
          end
        end
      end
      S_FETCH: begin
        // Issue four byte reads; shift each back in on the cycle after its read is issued.
        ma = faddr_q + AW'(fcnt_q[1:0]);
        if (fcnt_q != 3'd0) fword_d = {fword_q[23:0], rdata_q};
        if (fcnt_q == 3'd4) st_d = ret_q;
        else fcnt_d = fcnt_q + 3'd1;
      end
      S_HDR: begin
        hdr_we = 1'b1;
        if (hidx_q == 3'd7) st_d = S_CHK1;
        else begin
          hidx_d = hidx_q + 3'd1; faddr_d = faddr_q + AW'(4); fcnt_d = '0;
          st_d = S_FETCH;
        end
      end
      S_CHK1: begin
        if (hdr_q[0] != HdrMagic || hdr_q[1] != HdrSize || hdr_q[7] != 32'h0 ||
            image == 32'h0 || image > memory || memory > 32'(cap_i) ||
            memory > ~load_base_i || entry >= image || entry[0] ||
            count > ((n32 - 32'd32) >> 2)) begin
          rv_d = 1'b1; rk_d = 1'b0; rok_d = 1'b0; rent_d = '0; rmem_d = '0; rdat_d = '0;
          st_d = S_IDLE;
        end else st_d = S_CHK2;
      end
      S_CHK2: begin
        start_d = CW'(start32);
        if (image != n32 - start32 || ~crcf_q != hdr_q[6]) begin
          rv_d = 1'b1; rk_d = 1'b0; rok_d = 1'b0; rent_d = '0; rmem_d = '0; rdat_d = '0;
          st_d = S_IDLE;
        end else if (count == 32'h0) st_d = S_OK;
        else begin
          idx_d = '0; ptr_d = TblBase; faddr_d = TblBase; fcnt_d = '0;
          ret_d = S_OFFC; st_d = S_FETCH;
        end
      end
      S_OFFC: begin
        if (fw_full[0] || image < 32'd4 || fw_full > image - 32'd4 ||
            (idx_q != '0 && fw_full < prev_q + 32'd4)) begin
          rv_d = 1'b1; rk_d = 1'b0; rok_d = 1'b0; rent_d = '0; rmem_d = '0; rdat_d = '0;
          st_d = S_IDLE;
        end else begin
          off_d = fw_full;
          faddr_d = AW'(32'(start_q) + fw_full); fcnt_d = '0;
          ret_d = S_TGTC; st_d = S_FETCH;
        end
      end
      S_TGTC: begin
        if (fw_full > memory) begin
          rv_d = 1'b1; rk_d = 1'b0; rok_d = 1'b0; rent_d = '0; rmem_d = '0; rdat_d = '0;
          st_d = S_IDLE;
        end else begin
          prev_d = off_q; fcnt_d = '0; st_d = S_FETCH;
          if (last_idx) begin
            // Check pass done; start the patch pass from the first offset.
            idx_d = '0; ptr_d = TblBase; faddr_d = TblBase; ret_d = S_OFF2;
          end else begin
            idx_d = idx_q + CW'(1); ptr_d = ptr_q + AW'(4); faddr_d = ptr_q + AW'(4);
            ret_d = S_OFFC;
          end
        end
      end
      S_OFF2: begin
        taddr_d = AW'(32'(start_q) + fw_full);
        faddr_d = AW'(32'(start_q) + fw_full); fcnt_d = '0;
        ret_d = S_TGT2; st_d = S_FETCH;
      end
      S_TGT2: begin
        sum_d = fw_full + load_base_i; wcnt_d = '0; st_d = S_WR;
      end
      S_WR: begin
        ma  = taddr_q + AW'(wcnt_q);
        mwe = 1'b1;
        mwd = sum_q[31 - 8 * wcnt_q -: 8];
        wcnt_d = wcnt_q + 2'd1;
        if (wcnt_q == 2'd3) begin
          if (last_idx) st_d = S_OK;
          else begin
            idx_d = idx_q + CW'(1); ptr_d = ptr_q + AW'(4); faddr_d = ptr_q + AW'(4);
            fcnt_d = '0; ret_d = S_OFF2; st_d = S_FETCH;
          end
        end
      end
      S_OK: begin
        rv_d = 1'b1; rk_d = 1'b0; rok_d = 1'b1; rent_d = load_base_i + entry;
        rmem_d = memory[16:0]; rdat_d = '0;
        img_valid_d = 1'b1; img_len_d = image[16:0]; mem_len_d = memory[16:0];
        img_start_d = start_q; st_d = S_IDLE;
      end
      S_RDW: begin
        rv_d = 1'b1; rk_d = 1'b1; rok_d = 1'b0; rent_d = '0; rmem_d = '0;
        rdat_d = (mem_len_q != 17'h0) ? rdata_q : 8'h00;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ret_q <= ret_d; fcnt_q <= fcnt_d; hidx_q <= hidx_d; faddr_q <= faddr_d;
    ptr_q <= ptr_d; taddr_q <= taddr_d; fword_q <= fword_d; off_q <= off_d;
    prev_q <= prev_d; sum_q <= sum_d; n_q <= n_d; start_q <= start_d; idx_q <= idx_d;
    crcf_q <= crcf_d; wcnt_q <= wcnt_d;
    is_read_reply_o <= rk_d; package_ok_o <= rok_d; entry_address_o <= rent_d;
    memory_size_o <= rmem_d; read_data_o <= rdat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; res_valid_o <= 1'b0; img_valid_q <= 1'b0;
      img_len_q <= '0; mem_len_q <= '0; img_start_q <= '0;
    end else begin
      st_q <= st_d; res_valid_o <= rv_d; img_valid_q <= img_valid_d;
      img_len_q <= img_len_d; mem_len_q <= mem_len_d; img_start_q <= img_start_d;
    end
  end
endmodule
`default_nettype wire

// ----- sv/executable_package_validate_relocate.sv -----
// Load bytes give no result but the last one; a read reply is strobed once the queue
// ahead of it has drained, via state S_RDW and a registered read if an image is valid.
// A final byte's verdict follows a header fetch, a check pass and a patch pass over the
// offsets on one byte port. Throughput: one item per cycle into a two-deep queue while
// busy is low; the back end drains other loads at one per cycle, while a final byte or
// a read of a valid image holds it until its result is out. Results are strobed, so the
// receiver cannot stall. Reset clears counters, CRC and image state, not the store.
`timescale 1ns / 1ps
`default_nettype none
module executable_package_validate_relocate import epvr_pkg::*; #(
  parameter int BUFFER_BYTES = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        kind_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        final_byte_i,
  input  wire logic [15:0] read_address_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             result_valid_o,
  output logic             is_read_reply_o,
  output logic             package_ok_o,
  output logic [31:0]      entry_address_o,
  output logic [16:0]      memory_size_o,
  output logic [7:0]       read_data_o
);
  localparam int CW = $clog2(BUFFER_BYTES + 2);
  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int DW = $bits(cmd_t) + CW;

  logic          take, q_valid, q_full, q_pop;
  cmd_t          f_cmd, b_cmd;
  logic [CW-1:0] f_pos, b_pos;
  logic [DW-1:0] q_out;
  logic [31:0]   base_q;
  logic [16:0]   cap_q;

  // Accept while the queue has room.
  assign busy = q_full;
  assign take = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      cap_q  <= CapReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgLoadBase) base_q <= cfg_data_i;
      else cap_q <= cfg_data_i[16:0];
    end
  end

  epvr_front #(.BUFFER_BYTES(BUFFER_BYTES), .CW(CW)) u_front (
    .clk_i, .rst_ni, .take_i(take), .kind_i, .data_byte_i, .final_byte_i,
    .read_address_i, .cmd_o(f_cmd), .pos_o(f_pos)
  );

  epvr_queue #(.DW(DW)) u_queue (
    .clk_i, .rst_ni, .push_i(take), .push_data_i({f_cmd, f_pos}), .pop_i(q_pop),
    .pop_data_o(q_out), .valid_o(q_valid), .full_o(q_full)
  );

  assign b_cmd = q_out[DW-1:CW];
  assign b_pos = q_out[CW-1:0];

  epvr_back #(.BUFFER_BYTES(BUFFER_BYTES), .CW(CW), .AW(AW)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_i(b_cmd), .pos_i(b_pos),
    .cmd_pop_o(q_pop), .load_base_i(base_q), .cap_i(cap_q),
    .res_valid_o(result_valid_o), .is_read_reply_o, .package_ok_o, .entry_address_o,
    .memory_size_o, .read_data_o
  );
endmodule
`default_nettype wire

// ----- sv/epvr_checker.sv -----
// Port-level checks on result fields, bound to the top level.
// Depends on the top level's port list.
`timescale 1ns / 1ps
`default_nettype none
module epvr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        result_valid_o,
  input wire logic        is_read_reply_o,
  input wire logic        package_ok_o,
  input wire logic [31:0] entry_address_o,
  input wire logic [16:0] memory_size_o
);
  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && is_read_reply_o |-> !package_ok_o && entry_address_o == 32'h0 &&
    memory_size_o == 17'h0) else $error("read reply carries verdict fields");
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !is_read_reply_o && !package_ok_o |->
    entry_address_o == 32'h0 && memory_size_o == 17'h0) else $error("reject not zeroed");
  a_entry_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && package_ok_o |-> !entry_address_o[0] && memory_size_o != 17'h0)
    else $error("accepted package with odd entry or empty memory");
endmodule

bind executable_package_validate_relocate epvr_checker u_chk (
  .clk_i, .rst_ni, .result_valid_o, .is_read_reply_o, .package_ok_o, .entry_address_o,
  .memory_size_o
);
`default_nettype wire
